// ===== sv/smr_pkg.sv =====
package smr_pkg;

    localparam int RING_SLOTS_DEF  = 64;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int MAX_CLASSES_DEF = 64;

    localparam int TAG_W  = 32;
    localparam int SZ_W   = 27;
    localparam int SPAN_W = 51;
    localparam int CLS_W  = 7;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;
    localparam logic [23:0] SAT24 = 24'hFFFFFF;

    localparam logic [23:0] BASE_RST    = 24'd5000;
    localparam logic [19:0] STEP_RST    = 20'd250;
    localparam logic [6:0]  CLASSES_RST = 7'd21;
    localparam logic [23:0] BPC_RST     = 24'd12695;

    typedef enum logic [IDX_W-1:0] {
        REG_BASE    = 8'd0,
        REG_STEP    = 8'd1,
        REG_CLASSES = 8'd2,
        REG_BPC     = 8'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        K_HIT    = 3'd0,
        K_BAND   = 3'd1,
        K_FLUSH  = 3'd2,
        K_APPEND = 3'd3,
        K_REJECT = 3'd4
    } kind_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] block_addr;
        logic        request_end;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  slot;
        logic [31:0] band_start;
        logic [23:0] band_blocks;
        logic [23:0] in_band_pos;
        logic        last;
        logic        request_done;
    } res_t;

    typedef struct packed {
        logic [23:0] base;
        logic [19:0] step;
        logic [6:0]  classes;
        logic [23:0] bpc;
    } cfg_t;

    typedef struct packed {
        logic            found;
        logic [31:0]     start;
        logic [SZ_W-1:0] size;
    } band_res_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_CMP,
        B_DIV
    } band_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WB_WAIT,
        S_FL_LEAD,
        S_FL_LEADW,
        S_FL_BWAIT,
        S_FL_CHK,
        S_FL_CMP,
        S_SKIP_FL,
        S_FC_CHK,
        S_FC_CMP,
        S_FC_END,
        S_SKIP_END
    } st_t;

endpackage

// ===== sv/smr_ram.sv =====
module smr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/smr_band_unit.sv =====
module smr_band_unit #(
    parameter int MAX_CLASSES = smr_pkg::MAX_CLASSES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smr_pkg::cfg_t         cfg,
    input  logic                  go,
    input  logic [31:0]           addr,
    output logic                  done,
    output smr_pkg::band_res_t    res
);

    localparam int SZ_W   = smr_pkg::SZ_W;
    localparam int SPAN_W = smr_pkg::SPAN_W;
    localparam int CLS_W  = smr_pkg::CLS_W;
    localparam logic [CLS_W-1:0] MAXC = CLS_W'(MAX_CLASSES);

    smr_pkg::band_state_t state_reg, state_next;
    logic [31:0]       a_reg, a_next;
    logic [SZ_W-1:0]   sz_reg, sz_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic [31:0]       total_reg, total_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic [SZ_W-1:0]   rem_reg, rem_next;
    logic [31:0]       div_reg, div_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    smr_pkg::band_res_t res_reg, res_next;

    logic [CLS_W-1:0]  n_cls;
    logic [SPAN_W:0]   reach;
    logic [SZ_W:0]     trial;
    logic [SZ_W-1:0]   rem_step;

    assign done = done_reg;
    assign res  = res_reg;
    assign n_cls = (cfg.classes > MAXC) ? MAXC : cfg.classes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smr_pkg::B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        sz_reg    <= sz_next;
        span_reg  <= span_next;
        total_reg <= total_next;
        cls_reg   <= cls_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        sz_next    = sz_reg;
        span_next  = span_reg;
        total_next = total_reg;
        cls_next   = cls_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        reach      = (SPAN_W+1)'(total_reg) + (SPAN_W+1)'(span_reg);
        trial      = {rem_reg, div_reg[31]};
        rem_step   = (trial >= {1'b0, sz_reg}) ? SZ_W'(trial - {1'b0, sz_reg})
                                               : trial[SZ_W-1:0];
        unique case (state_reg)
            smr_pkg::B_IDLE:
            begin
                if (go)
                begin
                    a_next     = addr;
                    sz_next    = SZ_W'(cfg.base);
                    total_next = '0;
                    cls_next   = '0;
                    if (n_cls == '0)
                    begin
                        done_next      = 1'b1;
                        res_next.found = 1'b0;
                    end
                    else
                    begin
                        state_next = smr_pkg::B_MUL;
                    end
                end
            end
            smr_pkg::B_MUL:
            begin
                span_next  = sz_reg * cfg.bpc;
                state_next = smr_pkg::B_CMP;
            end
            smr_pkg::B_CMP:
            begin
                if (reach > (SPAN_W+1)'(a_reg))
                begin
                    if (sz_reg == '0)
                    begin
                        done_next      = 1'b1;
                        res_next.found = 1'b0;
                        state_next     = smr_pkg::B_IDLE;
                    end
                    else
                    begin
                        div_next   = a_reg - total_reg;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = smr_pkg::B_DIV;
                    end
                end
                else
                begin
                    total_next = reach[31:0];
                    cls_next   = cls_reg + 1'b1;
                    sz_next    = sz_reg + SZ_W'(cfg.step);
                    if (cls_reg + 1'b1 == n_cls)
                    begin
                        done_next      = 1'b1;
                        res_next.found = 1'b0;
                        state_next     = smr_pkg::B_IDLE;
                    end
                    else
                    begin
                        state_next = smr_pkg::B_MUL;
                    end
                end
            end
            smr_pkg::B_DIV:
            begin
                rem_next = rem_step;
                div_next = {div_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    done_next      = 1'b1;
                    res_next.found = 1'b1;
                    res_next.start = a_reg - 32'(rem_step);
                    res_next.size  = sz_reg;
                    state_next     = smr_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = smr_pkg::B_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/smr_persistent_buffer_log_core.sv =====
// A read scans the ring; a write adds a band search over the size classes and a
// bit-serial divide, and on a full ring a second band search and a flush walk.
// Throughput: one item at a time, set by the shared band unit and the tag RAM read port.
// Reset: asynchronous; clears state, pointers and valid bits; tag RAM is not cleared.
// Results are one-cycle strobes; the receiver cannot stall.
module smr_persistent_buffer_log_core #(
    parameter int RING_SLOTS  = smr_pkg::RING_SLOTS_DEF,
    parameter int ADDR_BITS   = smr_pkg::ADDR_BITS_DEF,
    parameter int MAX_CLASSES = smr_pkg::MAX_CLASSES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  smr_pkg::req_t            item,
    output logic                     result_valid,
    output smr_pkg::res_t            result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [smr_pkg::IDX_W-1:0]  cfg_index,
    input  logic [smr_pkg::DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int SZ_W   = smr_pkg::SZ_W;
    localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFFFFFF
                                        : 32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);
    localparam logic [SLOT_W:0]   SCAN_END  = (SLOT_W+1)'(RING_SLOTS);

    function automatic logic [SLOT_W-1:0] nxt(input logic [SLOT_W-1:0] s);
        nxt = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [23:0] sat24(input logic [SZ_W-1:0] v);
        sat24 = (v > SZ_W'(smr_pkg::SAT24)) ? smr_pkg::SAT24 : v[23:0];
    endfunction

    smr_pkg::st_t state_reg, state_next;
    smr_pkg::cfg_t cfg_reg, cfg_next;
    logic              mode_reg, mode_next;
    logic [31:0]       addr_reg, addr_next;
    logic              rend_reg, rend_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic              valid_reg [RING_SLOTS];
    logic              valid_next [RING_SLOTS];
    logic [SLOT_W:0]   idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] old_reg, old_next;
    logic [31:0]       lead_reg, lead_next;
    logic [31:0]       bstart_reg, bstart_next;
    logic [SZ_W-1:0]   bsize_reg, bsize_next;
    logic [SLOT_W-1:0] p_reg, p_next;
    logic              result_valid_reg, result_valid_next;
    smr_pkg::res_t     result_reg, result_next;

    logic              band_go;
    logic [31:0]       band_addr;
    logic              band_done;
    smr_pkg::band_res_t band_res;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic [32:0]       tdiff;

    assign busy         = (state_reg != smr_pkg::S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    smr_band_unit #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_band (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_reg),
        .go   (band_go),
        .addr (band_addr),
        .done (band_done),
        .res  (band_res)
    );

    smr_ram #(
        .WIDTH(smr_pkg::TAG_W),
        .DEPTH(RING_SLOTS)
    ) u_tags (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(addr_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= smr_pkg::S_IDLE;
            cfg_reg.base     <= smr_pkg::BASE_RST;
            cfg_reg.step     <= smr_pkg::STEP_RST;
            cfg_reg.classes  <= smr_pkg::CLASSES_RST;
            cfg_reg.bpc      <= smr_pkg::BPC_RST;
            head_reg         <= '0;
            tail_reg         <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < RING_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            cfg_reg          <= cfg_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            result_valid_reg <= result_valid_next;
            for (int i = 0; i < RING_SLOTS; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        addr_reg   <= addr_next;
        rend_reg   <= rend_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        old_reg    <= old_next;
        lead_reg   <= lead_next;
        bstart_reg <= bstart_next;
        bsize_reg  <= bsize_next;
        p_reg      <= p_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            priority case (cfg_index)
                smr_pkg::REG_BASE:    cfg_next.base    = cfg_data[23:0];
                smr_pkg::REG_STEP:    cfg_next.step    = cfg_data[19:0];
                smr_pkg::REG_CLASSES: cfg_next.classes = cfg_data[6:0];
                smr_pkg::REG_BPC:     cfg_next.bpc     = cfg_data[23:0];
                default:              cfg_next         = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        addr_next         = addr_reg;
        rend_next         = rend_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        idx_next          = idx_reg;
        found_next        = found_reg;
        old_next          = old_reg;
        lead_next         = lead_reg;
        bstart_next       = bstart_reg;
        bsize_next        = bsize_reg;
        p_next            = p_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        band_go           = 1'b0;
        band_addr         = addr_reg;
        ram_we            = 1'b0;
        ram_raddr         = p_reg;
        tdiff             = {1'b0, ram_rdata} - {1'b0, bstart_reg};
        for (int i = 0; i < RING_SLOTS; i++)
        begin
            valid_next[i] = valid_reg[i];
        end

        unique case (state_reg)
            smr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = item.mode;
                    addr_next  = item.block_addr & ADDR_MASK;
                    rend_next  = item.request_end;
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (item.mode)
                    begin
                        band_go    = 1'b1;
                        band_addr  = item.block_addr & ADDR_MASK;
                        state_next = smr_pkg::S_WB_WAIT;
                    end
                    else
                    begin
                        state_next = smr_pkg::S_FC_CHK;
                    end
                end
            end
            smr_pkg::S_WB_WAIT:
            begin
                if (band_done)
                begin
                    if (!band_res.found)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = '0;
                        result_next.kind  = smr_pkg::K_REJECT;
                        result_next.last  = 1'b1;
                        result_next.request_done = rend_reg;
                        state_next        = smr_pkg::S_IDLE;
                    end
                    else if (nxt(tail_reg) == head_reg)
                    begin
                        state_next = smr_pkg::S_FL_LEAD;
                    end
                    else
                    begin
                        state_next = smr_pkg::S_FC_CHK;
                    end
                end
            end
            smr_pkg::S_FL_LEAD:
            begin
                ram_raddr  = head_reg;
                state_next = smr_pkg::S_FL_LEADW;
            end
            smr_pkg::S_FL_LEADW:
            begin
                lead_next  = ram_rdata;
                band_go    = 1'b1;
                band_addr  = ram_rdata;
                state_next = smr_pkg::S_FL_BWAIT;
            end
            smr_pkg::S_FL_BWAIT:
            begin
                if (band_done)
                begin
                    if (!band_res.found)
                    begin
                        result_valid_next      = 1'b1;
                        result_next            = '0;
                        result_next.kind       = smr_pkg::K_FLUSH;
                        result_next.slot       = 6'(head_reg);
                        result_next.band_start = lead_reg;
                        valid_next[head_reg]   = 1'b0;
                        state_next             = smr_pkg::S_SKIP_FL;
                    end
                    else
                    begin
                        bstart_next = band_res.start;
                        bsize_next  = band_res.size;
                        p_next      = head_reg;
                        state_next  = smr_pkg::S_FL_CHK;
                    end
                end
            end
            smr_pkg::S_FL_CHK:
            begin
                if (p_reg == tail_reg)
                begin
                    state_next = smr_pkg::S_SKIP_FL;
                end
                else if (valid_reg[p_reg])
                begin
                    ram_raddr  = p_reg;
                    state_next = smr_pkg::S_FL_CMP;
                end
                else
                begin
                    p_next = nxt(p_reg);
                end
            end
            smr_pkg::S_FL_CMP:
            begin
                if (!tdiff[32] && (tdiff[31:0] < 32'(bsize_reg)))
                begin
                    result_valid_next       = 1'b1;
                    result_next             = '0;
                    result_next.kind        = smr_pkg::K_FLUSH;
                    result_next.slot        = 6'(p_reg);
                    result_next.band_start  = bstart_reg;
                    result_next.band_blocks = sat24(bsize_reg);
                    result_next.in_band_pos = sat24(tdiff[SZ_W-1:0]);
                    valid_next[p_reg]       = 1'b0;
                end
                p_next     = nxt(p_reg);
                state_next = smr_pkg::S_FL_CHK;
            end
            smr_pkg::S_SKIP_FL:
            begin
                if (head_reg != tail_reg && !valid_reg[head_reg])
                begin
                    head_next = nxt(head_reg);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = smr_pkg::S_FC_CHK;
                end
            end
            smr_pkg::S_FC_CHK:
            begin
                ram_raddr = idx_reg[SLOT_W-1:0];
                if (idx_reg == SCAN_END)
                begin
                    state_next = smr_pkg::S_FC_END;
                end
                else if (valid_reg[idx_reg[SLOT_W-1:0]])
                begin
                    state_next = smr_pkg::S_FC_CMP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            smr_pkg::S_FC_CMP:
            begin
                if (ram_rdata == addr_reg)
                begin
                    found_next = 1'b1;
                    old_next   = idx_reg[SLOT_W-1:0];
                    state_next = smr_pkg::S_FC_END;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = smr_pkg::S_FC_CHK;
                end
            end
            smr_pkg::S_FC_END:
            begin
                result_valid_next        = 1'b1;
                result_next              = '0;
                result_next.last         = 1'b1;
                result_next.request_done = rend_reg;
                if (!mode_reg)
                begin
                    result_next.kind = found_reg ? smr_pkg::K_HIT : smr_pkg::K_BAND;
                    result_next.slot = found_reg ? 6'(old_reg) : 6'd0;
                    state_next       = smr_pkg::S_IDLE;
                end
                else
                begin
                    result_next.kind     = smr_pkg::K_APPEND;
                    result_next.slot     = 6'(tail_reg);
                    ram_we               = 1'b1;
                    valid_next[tail_reg] = 1'b1;
                    tail_next            = nxt(tail_reg);
                    if (found_reg)
                    begin
                        valid_next[old_reg] = 1'b0;
                        state_next          = smr_pkg::S_SKIP_END;
                    end
                    else
                    begin
                        state_next = smr_pkg::S_IDLE;
                    end
                end
            end
            smr_pkg::S_SKIP_END:
            begin
                if (head_reg != tail_reg && !valid_reg[head_reg])
                begin
                    head_next = nxt(head_reg);
                end
                else
                begin
                    state_next = smr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = smr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    smr_pkg::req_t  item;
    logic           result_valid;
    smr_pkg::res_t  result;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [7:0]     cfg_index;
    logic [31:0]    cfg_data;

    smr_persistent_buffer_log_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow of the log state and registers
    longint unsigned base_blk, step_blk, num_classes, bands_cls;
    bit              shadow_valid [SLOTS];
    longint unsigned shadow_tag [SLOTS];
    int unsigned     head_slot, tail_slot;

    smr_pkg::res_t pending_results [$];
    int            error_count;
    int unsigned   addr_pool [100];

    typedef struct {
        bit             mode;
        logic [31:0]    addr;
        bit             rend;
        bit             typed;
        smr_pkg::kind_t kind;
        logic [5:0]     slot;
    } access_row_t;

    function automatic int unsigned next_of(int unsigned s);
        return (s + 1) % SLOTS;
    endfunction

    function automatic bit locate_band(longint unsigned a, output longint unsigned bstart,
                                       output longint unsigned bsize);
        longint unsigned total, sz, span, n;
        total = 0;
        bstart = 0;
        bsize = 0;
        n = (num_classes > 64) ? 64 : num_classes;
        for (longint unsigned i = 0; i < n; i++)
        begin
            sz = base_blk + i * step_blk;
            span = sz * bands_cls;
            if (total + span > a)
            begin
                if (sz == 0)
                    return 0;
                bstart = total + ((a - total) / sz) * sz;
                bsize = sz;
                return 1;
            end
            total += span;
        end
        return 0;
    endfunction

    function automatic longint unsigned region_blocks();
        longint unsigned total, n;
        total = 0;
        n = (num_classes > 64) ? 64 : num_classes;
        for (longint unsigned i = 0; i < n; i++)
            total += (base_blk + i * step_blk) * bands_cls;
        return total;
    endfunction

    function automatic void emit(smr_pkg::kind_t k, int unsigned s, longint unsigned bstart,
                                 longint unsigned bsize, longint unsigned pos);
        smr_pkg::res_t r;
        r.kind = k;
        r.slot = s[5:0];
        r.band_start = bstart[31:0];
        r.band_blocks = (bsize > 64'hFFFFFF) ? smr_pkg::SAT24 : bsize[23:0];
        r.in_band_pos = (pos > 64'hFFFFFF) ? smr_pkg::SAT24 : pos[23:0];
        r.last = 1'b0;
        r.request_done = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void skip_invalid_head();
        while (head_slot != tail_slot && !shadow_valid[head_slot])
            head_slot = next_of(head_slot);
    endfunction

    function automatic int find_copy(longint unsigned a);
        for (int s = 0; s < SLOTS; s++)
            if (shadow_valid[s] && shadow_tag[s] == a)
                return s;
        return -1;
    endfunction

    function automatic void flush_head_band();
        longint unsigned lead, bstart, bsize, t;
        int unsigned p;
        if (head_slot == tail_slot)
            return;
        lead = shadow_tag[head_slot];
        if (!locate_band(lead, bstart, bsize))
        begin
            emit(smr_pkg::K_FLUSH, head_slot, lead, 0, 0);
            shadow_valid[head_slot] = 0;
            skip_invalid_head();
            return;
        end
        p = head_slot;
        while (p != tail_slot)
        begin
            t = shadow_tag[p];
            if (shadow_valid[p] && t >= bstart && t - bstart < bsize)
            begin
                emit(smr_pkg::K_FLUSH, p, bstart, bsize, t - bstart);
                shadow_valid[p] = 0;
            end
            p = next_of(p);
        end
        skip_invalid_head();
    endfunction

    function automatic void predict_access(smr_pkg::req_t r);
        longint unsigned a, bs, bz;
        int old;
        int unsigned ns;
        a = r.block_addr;
        if (!r.mode)
        begin
            old = find_copy(a);
            if (old >= 0)
                emit(smr_pkg::K_HIT, old, 0, 0, 0);
            else
                emit(smr_pkg::K_BAND, 0, 0, 0, 0);
        end
        else if (!locate_band(a, bs, bz))
            emit(smr_pkg::K_REJECT, 0, 0, 0, 0);
        else
        begin
            if (next_of(tail_slot) == head_slot)
                flush_head_band();
            old = find_copy(a);
            ns = tail_slot;
            shadow_tag[ns] = a;
            shadow_valid[ns] = 1;
            tail_slot = next_of(tail_slot);
            if (old >= 0)
            begin
                shadow_valid[old] = 0;
                skip_invalid_head();
            end
            emit(smr_pkg::K_APPEND, ns, 0, 0, 0);
        end
        pending_results[$].last = 1'b1;
        pending_results[$].request_done = r.request_end;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        smr_pkg::res_t e;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result kind=%0d slot=%0d", result.kind, result.slot);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (result.kind !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, result.kind);
                    error_count++;
                end
                if (result.slot !== e.slot)
                begin
                    $error("slot: expected %0d, got %0d", e.slot, result.slot);
                    error_count++;
                end
                if (result.band_start !== e.band_start)
                begin
                    $error("band_start: expected %0h, got %0h", e.band_start, result.band_start);
                    error_count++;
                end
                if (result.band_blocks !== e.band_blocks)
                begin
                    $error("band_blocks: expected %0h, got %0h", e.band_blocks,
                           result.band_blocks);
                    error_count++;
                end
                if (result.in_band_pos !== e.in_band_pos)
                begin
                    $error("in_band_pos: expected %0h, got %0h", e.in_band_pos,
                           result.in_band_pos);
                    error_count++;
                end
                if (result.last !== e.last)
                begin
                    $error("last: expected %0b, got %0b", e.last, result.last);
                    error_count++;
                end
                if (result.request_done !== e.request_done)
                begin
                    $error("request_done: expected %0b, got %0b", e.request_done,
                           result.request_done);
                    error_count++;
                end
            end
        end
    end

    task automatic send_access(smr_pkg::req_t r, bit typed, smr_pkg::kind_t k, logic [5:0] s);
        item <= r;
        start <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_access(r);
        if (typed)
        begin
            pending_results[$].kind = k;
            pending_results[$].slot = s;
        end
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            smr_pkg::REG_BASE:    base_blk = data[23:0];
            smr_pkg::REG_STEP:    step_blk = data[19:0];
            smr_pkg::REG_CLASSES: num_classes = data[6:0];
            smr_pkg::REG_BPC:     bands_cls = data[23:0];
            default:              ;
        endcase
    endtask

    task automatic set_layout(logic [23:0] b, logic [19:0] st, logic [6:0] c, logic [23:0] n);
        longint unsigned reg_top;
        drain();
        write_reg(smr_pkg::REG_BASE, {8'($urandom_range(0, 255)), b});
        write_reg(smr_pkg::REG_STEP, {12'($urandom), st});
        write_reg(smr_pkg::REG_CLASSES, {25'($urandom), c});
        write_reg(smr_pkg::REG_BPC, {8'($urandom_range(0, 255)), n});
        write_reg(8'($urandom_range(4, 255)), $urandom);
        cfg_valid <= 1'b0;
        reg_top = region_blocks();
        foreach (addr_pool[j])
        begin
            if (reg_top == 0)
                addr_pool[j] = $urandom;
            else if (reg_top > 64'hFFFFFFFF)
                addr_pool[j] = $urandom;
            else
                addr_pool[j] = $urandom_range(0, 32'(reg_top - 1));
        end
    endtask

    task automatic random_phase(int count, int write_pct, bit gaps);
        smr_pkg::req_t r;
        int            pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            r.mode = ($urandom_range(0, 99) < write_pct);
            if (pick < 80)
                r.block_addr = addr_pool[$urandom_range(0, 99)];
            else if (pick < 90)
                r.block_addr = addr_pool[$urandom_range(0, 99)] + $urandom_range(0, 3);
            else
                r.block_addr = $urandom;
            r.request_end = $urandom_range(0, 1);
            send_access(r, 1'b0, smr_pkg::K_HIT, 6'd0);
            if (i == count / 2)
                drain();
            else if (gaps && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 13));
        end
    endtask

    initial
    begin
        #30ms;
        $display("smr_persistent_buffer_log_core regression: fail");
        $finish;
    end

    initial
    begin
        access_row_t   rows [$];
        smr_pkg::req_t r;

        error_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        base_blk = smr_pkg::BASE_RST;
        step_blk = smr_pkg::STEP_RST;
        num_classes = smr_pkg::CLASSES_RST;
        bands_cls = smr_pkg::BPC_RST;
        head_slot = 0;
        tail_slot = 0;
        foreach (shadow_valid[s])
        begin
            shadow_valid[s] = 0;
            shadow_tag[s] = 0;
        end

        rows = '{
            '{1'b0, 32'd0,        1'b0, 1'b1, smr_pkg::K_BAND,   6'd0},
            '{1'b1, 32'hFFFFFFFF, 1'b1, 1'b1, smr_pkg::K_REJECT, 6'd0},
            '{1'b1, 32'd0,        1'b1, 1'b1, smr_pkg::K_APPEND, 6'd0},
            '{1'b0, 32'd0,        1'b0, 1'b1, smr_pkg::K_HIT,    6'd0},
            '{1'b1, 32'd0,        1'b0, 1'b1, smr_pkg::K_APPEND, 6'd1},
            '{1'b0, 32'd0,        1'b1, 1'b1, smr_pkg::K_HIT,    6'd1},
            '{1'b0, 32'hFFFFFFFF, 1'b1, 1'b1, smr_pkg::K_BAND,   6'd0},
            '{1'b1, 32'd4999,     1'b0, 1'b0, smr_pkg::K_HIT,    6'd0},
            '{1'b1, 32'd5000,     1'b1, 1'b0, smr_pkg::K_HIT,    6'd0},
            '{1'b1, 32'h7FFFFFFF, 1'b0, 1'b0, smr_pkg::K_HIT,    6'd0},
            '{1'b1, 32'h80000000, 1'b1, 1'b0, smr_pkg::K_HIT,    6'd0},
            '{1'b1, 32'd63466666, 1'b0, 1'b0, smr_pkg::K_HIT,    6'd0},
            '{1'b0, 32'd4999,     1'b1, 1'b0, smr_pkg::K_HIT,    6'd0},
            '{1'b0, 32'h55555555, 1'b0, 1'b0, smr_pkg::K_HIT,    6'd0},
            '{1'b1, 32'hAAAAAAAA, 1'b1, 1'b0, smr_pkg::K_HIT,    6'd0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r.mode = rows[i].mode;
            r.block_addr = rows[i].addr;
            r.request_end = rows[i].rend;
            send_access(r, rows[i].typed, rows[i].kind, rows[i].slot);
        end

        set_layout(smr_pkg::BASE_RST, smr_pkg::STEP_RST, smr_pkg::CLASSES_RST,
                   smr_pkg::BPC_RST);
        random_phase(60, 65, 1'b1);
        set_layout(24'd4, 20'd3, 7'd4, 24'd8);
        random_phase(120, 70, 1'b1);
        set_layout(24'd4, 20'd0, 7'd1, 24'd2);
        random_phase(50, 75, 1'b1);
        set_layout(24'd1, 20'd0, 7'd1, 24'd1);
        random_phase(20, 60, 1'b1);
        set_layout(24'd5, 20'd1, 7'd0, 24'd3);
        random_phase(20, 70, 1'b1);
        set_layout(24'hFFFFFF, 20'hFFFFF, 7'd127, 24'd1);
        random_phase(90, 75, 1'b1);
        set_layout(24'd2, 20'd1, 7'd64, 24'd3);
        random_phase(100, 70, 1'b0);

        drain();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("smr_persistent_buffer_log_core regression: pass");
        else
            $display("smr_persistent_buffer_log_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/smr_pkg.sv
sv/smr_ram.sv
sv/smr_band_unit.sv
sv/smr_persistent_buffer_log_core.sv
dv/tb.sv
